// File: design/swbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_pkg
// Shared types, constants and helpers of the wave bond force pipeline.
// ----------------------------------------------------------------------------
package swbf_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int SQ_STG    = 32;
    localparam int DV_STG    = 32;

    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598669;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STIFFNESS   = 4'd0,
        REG_REST_LENGTH = 4'd1,
        REG_AMP_BASE    = 4'd2,
        REG_AMP_SLOPE   = 4'd3,
        REG_FREQ_BASE   = 4'd4,
        REG_FREQ_SLOPE  = 4'd5,
        REG_CHAIN_FIRST = 4'd6,
        REG_CHAIN_LAST  = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic               status;
    } t_car;

    typedef struct packed {
        t_car               car;
        logic signed [34:0] rest;
    } t_sq_side;

    typedef struct packed {
        t_car car;
        logic neg;
        logic zero;
    } t_dv_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/swbf_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_isqrt
// Pipelined integer square root, one root bit per stage, with side payload.
// ----------------------------------------------------------------------------
module swbf_isqrt (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [63:0]       i_rad,
    input  wire swbf_pkg::t_sq_side i_side,
    output logic                   o_vld,
    output logic [31:0]            o_root,
    output swbf_pkg::t_sq_side     o_side
);
    import swbf_pkg::*;

    logic        r_vld  [SQ_STG];
    logic [31:0] r_q    [SQ_STG];
    logic [63:0] r_rem  [SQ_STG];
    t_sq_side    r_side [SQ_STG];
    logic [31:0] n_q    [SQ_STG];
    logic [63:0] n_rem  [SQ_STG];
    logic [31:0] s_q    [SQ_STG];
    logic [63:0] s_rem  [SQ_STG];

    always_comb begin
        logic [65:0] trial;
        s_q[0]   = '0;
        s_rem[0] = i_rad;
        for (int k = 1; k < SQ_STG; k++) begin
            s_q[k]   = r_q[k-1];
            s_rem[k] = r_rem[k-1];
        end
        for (int k = 0; k < SQ_STG; k++) begin
            trial = (66'(s_q[k]) << (SQ_STG - k)) + (66'(1) << (2 * (SQ_STG - 1 - k)));
            if (66'(s_rem[k]) >= trial) begin
                n_rem[k] = s_rem[k] - trial[63:0];
                n_q[k]   = s_q[k] | (32'(1) << (SQ_STG - 1 - k));
            end else begin
                n_rem[k] = s_rem[k];
                n_q[k]   = s_q[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STG; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < SQ_STG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < SQ_STG; k++) r_side[k] <= r_side[k-1];
            for (int k = 0; k < SQ_STG; k++) begin
                r_q[k]   <= n_q[k];
                r_rem[k] <= n_rem[k];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STG-1];
    assign o_root = r_q[SQ_STG-1];
    assign o_side = r_side[SQ_STG-1];

endmodule
`default_nettype wire

// File: design/swbf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swbf_div
// Pipelined restoring divider, quotient saturated at 2^31, with side payload.
// ----------------------------------------------------------------------------
module swbf_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [65:0]       i_num,
    input  wire logic [31:0]       i_den,
    input  wire swbf_pkg::t_dv_side i_side,
    output logic                   o_vld,
    output logic [31:0]            o_quo,
    output swbf_pkg::t_dv_side     o_side
);
    import swbf_pkg::*;

    logic        r_vld  [DV_STG];
    logic        r_sat  [DV_STG];
    logic [31:0] r_den  [DV_STG];
    logic [62:0] r_rem  [DV_STG];
    logic [30:0] r_q    [DV_STG];
    t_dv_side    r_side [DV_STG];
    logic [62:0] n_rem  [DV_STG];
    logic [30:0] n_q    [DV_STG];

    always_comb begin
        logic [62:0] trial;
        n_rem[0] = i_num[62:0];
        n_q[0]   = '0;
        for (int k = 1; k < DV_STG; k++) begin
            trial = 63'(r_den[k-1]) << (DV_STG - 1 - k);
            if (r_rem[k-1] >= trial) begin
                n_rem[k] = r_rem[k-1] - trial;
                n_q[k]   = r_q[k-1] | (31'(1) << (DV_STG - 1 - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_q[k]   = r_q[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DV_STG; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < DV_STG; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_den[0]  <= i_den;
            r_sat[0]  <= (i_num >= {3'b0, i_den, 31'b0});
            for (int k = 1; k < DV_STG; k++) begin
                r_side[k] <= r_side[k-1];
                r_den[k]  <= r_den[k-1];
                r_sat[k]  <= r_sat[k-1];
            end
            for (int k = 0; k < DV_STG; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_vld  = r_vld[DV_STG-1];
    assign o_quo  = r_sat[DV_STG-1] ? ONE_Q30 << 1 : {1'b0, r_q[DV_STG-1]};
    assign o_side = r_side[DV_STG-1];

endmodule
`default_nettype wire

// File: design/swimmer_wave_bond_force.sv
// throughput: one bond per cycle; the whole pipeline holds while the result is stalled
// the 32-stage root and 32-stage divide pipelines make up most of the latency
// reset: synchronous active low, clears valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swimmer_wave_bond_force
// Harmonic bond force with a traveling wave rest length, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module swimmer_wave_bond_force (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [swbf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [31:0]            i_delta_x,
    input  wire logic signed [31:0]            i_delta_y,
    input  wire logic signed [31:0]            i_delta_z,
    input  wire logic [30:0]                   i_tag_first,
    input  wire logic [30:0]                   i_tag_second,
    input  wire logic [31:0]                   i_wave_phase,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [31:0]                 o_force_x,
    output logic signed [31:0]                 o_force_y,
    output logic signed [31:0]                 o_force_z,
    output logic signed [31:0]                 o_force_scale,
    output logic                               o_status
);
    import swbf_pkg::*;

    localparam int FR_STG = 12;

    typedef struct packed {
        t_car               car;
        logic [63:0]        sqx;
        logic [63:0]        sqy;
        logic [63:0]        sqz;
        logic [63:0]        rsq;
        logic               match;
        logic [30:0]        dn;
        logic [31:0]        dn2;
        logic [31:0]        fbdn;
        logic signed [63:0] adn;
        logic [31:0]        phase;
        logic [31:0]        theta;
        logic signed [31:0] a;
        logic [1:0]         quad;
        logic [30:0]        x;
        logic [30:0]        x2;
        logic [30:0]        p;
        logic signed [31:0] s;
        logic signed [63:0] aprod;
        logic signed [34:0] rest;
    } t_fr;

    typedef struct packed {
        t_car               car;
        logic [31:0]        root;
        logic [33:0]        ad;
        logic               neg;
        logic               zero;
    } t_p1;

    typedef struct packed {
        t_car               car;
        logic [31:0]        root;
        logic [47:0]        ph;
        logic [47:0]        pl;
        logic               neg;
        logic               zero;
    } t_p2;

    logic [30:0]        r_stiffness;
    logic [30:0]        r_rest_length;
    logic signed [31:0] r_amp_base;
    logic signed [31:0] r_amp_slope;
    logic [31:0]        r_freq_base;
    logic [31:0]        r_freq_slope;
    logic [30:0]        r_chain_first;
    logic [30:0]        r_chain_last;

    logic adv;

    logic r_fv [FR_STG];
    t_fr  r_fr [FR_STG];
    t_fr  n_fr [FR_STG];

    logic     sq_vld;
    logic [31:0] sq_root;
    t_sq_side sq_side_in;
    t_sq_side sq_side;

    logic r_p1_vld;
    t_p1  r_p1;
    t_p1  n_p1;
    logic r_p2_vld;
    t_p2  r_p2;

    logic [65:0] dv_num;
    t_dv_side    dv_side_in;
    logic        dv_vld;
    logic [31:0] dv_quo;
    t_dv_side    dv_side;

    logic               r_f1_vld;
    logic signed [31:0] r_f1_fs;
    t_car               r_f1_car;
    logic signed [31:0] n_f1_fs;
    logic               r_f2_vld;
    logic signed [31:0] r_f2_fs;
    logic               r_f2_status;
    logic signed [63:0] r_f2_px;
    logic signed [63:0] r_f2_py;
    logic signed [63:0] r_f2_pz;
    logic               r_out_vld;

    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiffness   <= 31'd65536;
            r_rest_length <= 31'd65536;
            r_amp_base    <= '0;
            r_amp_slope   <= '0;
            r_freq_base   <= '0;
            r_freq_slope  <= '0;
            r_chain_first <= '0;
            r_chain_last  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_STIFFNESS:   r_stiffness   <= i_cfg_data[30:0];
                REG_REST_LENGTH: r_rest_length <= i_cfg_data[30:0];
                REG_AMP_BASE:    r_amp_base    <= $signed(i_cfg_data);
                REG_AMP_SLOPE:   r_amp_slope   <= $signed(i_cfg_data);
                REG_FREQ_BASE:   r_freq_base   <= i_cfg_data;
                REG_FREQ_SLOPE:  r_freq_slope  <= i_cfg_data;
                REG_CHAIN_FIRST: r_chain_first <= i_cfg_data[30:0];
                REG_CHAIN_LAST:  r_chain_last  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front stages: squares, wave angle, sine, rest length
    always_comb begin
        logic [61:0] y;
        n_fr[0]            = r_fr[FR_STG-1];
        n_fr[0].car.dx     = i_delta_x;
        n_fr[0].car.dy     = i_delta_y;
        n_fr[0].car.dz     = i_delta_z;
        n_fr[0].car.status = (i_tag_first >= i_tag_second);
        n_fr[0].sqx        = $unsigned(64'(i_delta_x) * 64'(i_delta_x));
        n_fr[0].sqy        = $unsigned(64'(i_delta_y) * 64'(i_delta_y));
        n_fr[0].sqz        = $unsigned(64'(i_delta_z) * 64'(i_delta_z));
        n_fr[0].dn         = i_tag_first - r_chain_first;
        n_fr[0].match      = (i_tag_first >= r_chain_first) && (i_tag_first <= r_chain_last)
                             && ({1'b0, i_tag_second} == {1'b0, i_tag_first} + 32'd1);
        n_fr[0].phase      = i_wave_phase;

        n_fr[1]      = r_fr[0];
        n_fr[1].rsq  = r_fr[0].sqx + r_fr[0].sqy + r_fr[0].sqz;
        n_fr[1].dn2  = 32'(62'(r_fr[0].dn) * 62'(r_fr[0].dn));
        n_fr[1].fbdn = 32'(63'(r_freq_base) * 63'(r_fr[0].dn));
        n_fr[1].adn  = 64'(r_amp_slope) * $signed(64'(r_fr[0].dn));

        n_fr[2]       = r_fr[1];
        n_fr[2].theta = 32'(64'(r_freq_slope) * 64'(r_fr[1].dn2)) + r_fr[1].fbdn
                        + r_fr[1].phase;
        n_fr[2].a     = sat32(r_fr[1].adn + 64'(r_amp_base));

        n_fr[3]      = r_fr[2];
        n_fr[3].quad = r_fr[2].theta[31:30];
        n_fr[3].x    = r_fr[2].theta[30] ? 31'(ONE_Q30 - {2'b0, r_fr[2].theta[29:0]})
                                         : {1'b0, r_fr[2].theta[29:0]};

        n_fr[4]    = r_fr[3];
        n_fr[4].x2 = 31'((62'(r_fr[3].x) * 62'(r_fr[3].x)) >> 30);

        n_fr[5]   = r_fr[4];
        n_fr[5].p = SIN_C7 - 31'((62'(r_fr[4].x2) * 62'(SIN_C9)) >> 30);
        n_fr[6]   = r_fr[5];
        n_fr[6].p = SIN_C5 - 31'((62'(r_fr[5].x2) * 62'(r_fr[5].p)) >> 30);
        n_fr[7]   = r_fr[6];
        n_fr[7].p = SIN_C3 - 31'((62'(r_fr[6].x2) * 62'(r_fr[6].p)) >> 30);
        n_fr[8]   = r_fr[7];
        n_fr[8].p = SIN_C1 - 31'((62'(r_fr[7].x2) * 62'(r_fr[7].p)) >> 30);

        n_fr[9] = r_fr[8];
        y       = (62'(r_fr[8].x) * 62'(r_fr[8].p)) >> 30;
        if (y > 62'(ONE_Q30)) begin
            y = 62'(ONE_Q30);
        end
        n_fr[9].s = r_fr[8].quad[1] ? -$signed(32'(y)) : $signed(32'(y));

        n_fr[10]       = r_fr[9];
        n_fr[10].aprod = 64'(r_fr[9].a) * 64'(r_fr[9].s);

        n_fr[11]      = r_fr[10];
        n_fr[11].rest = r_fr[10].match
                        ? $signed(35'(r_rest_length)) + 35'(r_fr[10].aprod >>> 30)
                        : $signed(35'(r_rest_length));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FR_STG; k++) r_fv[k] <= 1'b0;
        end else if (adv) begin
            r_fv[0] <= i_in_valid;
            for (int k = 1; k < FR_STG; k++) r_fv[k] <= r_fv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < FR_STG; k++) r_fr[k] <= n_fr[k];
        end
    end

    assign sq_side_in.car  = r_fr[FR_STG-1].car;
    assign sq_side_in.rest = r_fr[FR_STG-1].rest;

    swbf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_fv[FR_STG-1]),
        .i_rad   (r_fr[FR_STG-1].rsq),
        .i_side  (sq_side_in),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stretch and its magnitude
    always_comb begin
        logic signed [34:0] dr;
        dr        = $signed({3'b0, sq_root}) - sq_side.rest;
        n_p1.car  = sq_side.car;
        n_p1.root = sq_root;
        n_p1.ad   = dr[34] ? 34'(-dr) : 34'(dr);
        n_p1.neg  = !dr[34] && (dr != '0);
        n_p1.zero = (sq_root == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else if (adv) begin
            r_p1_vld <= sq_vld;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1      <= n_p1;
            r_p2.car  <= r_p1.car;
            r_p2.root <= r_p1.root;
            r_p2.neg  <= r_p1.neg;
            r_p2.zero <= r_p1.zero;
            r_p2.ph   <= 48'(r_stiffness) * 48'(r_p1.ad[33:17]);
            r_p2.pl   <= 48'(r_stiffness) * 48'(r_p1.ad[16:0]);
        end
    end

    assign dv_num          = ((66'(r_p2.ph) << 17) + 66'(r_p2.pl)) << 1;
    assign dv_side_in.car  = r_p2.car;
    assign dv_side_in.neg  = r_p2.neg;
    assign dv_side_in.zero = r_p2.zero;

    swbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_p2_vld),
        .i_num   (dv_num),
        .i_den   (r_p2.root),
        .i_side  (dv_side_in),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // force scale, component products, output register
    always_comb begin
        if (dv_side.zero) begin
            n_f1_fs = '0;
        end else if (dv_side.neg) begin
            n_f1_fs = $signed(32'd0 - dv_quo);
        end else if (dv_quo[31]) begin
            n_f1_fs = 32'sh7FFF_FFFF;
        end else begin
            n_f1_fs = $signed(dv_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_f1_vld  <= dv_vld;
            r_f2_vld  <= r_f1_vld;
            r_out_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_fs       <= n_f1_fs;
            r_f1_car      <= dv_side.car;
            r_f2_fs       <= r_f1_fs;
            r_f2_status   <= r_f1_car.status;
            r_f2_px       <= 64'(r_f1_fs) * 64'(r_f1_car.dx);
            r_f2_py       <= 64'(r_f1_fs) * 64'(r_f1_car.dy);
            r_f2_pz       <= 64'(r_f1_fs) * 64'(r_f1_car.dz);
            o_force_x     <= sat32(r_f2_px >>> 16);
            o_force_y     <= sat32(r_f2_py >>> 16);
            o_force_z     <= sat32(r_f2_pz >>> 16);
            o_force_scale <= r_f2_fs;
            o_status      <= r_f2_status;
        end
    end

    assign o_out_valid = r_out_vld;

`ifndef SYNTHESIS
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_force_scale == '0)
        |-> (o_force_x == '0) && (o_force_y == '0) && (o_force_z == '0))
        else $error("nonzero force with zero scale");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv[0] && !adv |=> r_fv[0] && $stable(r_fr[0]))
        else $error("front stage changed during stall");

    a_stretch_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld && r_p1.neg |-> (r_p1.ad != '0))
        else $error("positive stretch with zero magnitude");
`endif

endmodule
`default_nettype wire

// File: bench/tb_bond_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bond_checker
// Watches the bond and force channels and the register port, computes the
// expected force of every bond transfer and compares it with each result.
// ----------------------------------------------------------------------------
module tb_bond_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic signed [31:0] i_delta_x,
    input  wire logic signed [31:0] i_delta_y,
    input  wire logic signed [31:0] i_delta_z,
    input  wire logic [30:0]        i_tag_first,
    input  wire logic [30:0]        i_tag_second,
    input  wire logic [31:0]        i_wave_phase,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic signed [31:0] i_force_x,
    input  wire logic signed [31:0] i_force_y,
    input  wire logic signed [31:0] i_force_z,
    input  wire logic signed [31:0] i_force_scale,
    input  wire logic               i_status,
    output int                      o_errors,
    output int                      o_pending
);
    import swbf_pkg::*;

    typedef struct packed {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [31:0] fs;
        logic               st;
    } t_force;

    t_force      force_q[$];
    logic [30:0] k_reg, r0_reg, first_reg, last_reg;
    logic [31:0] fb_reg, fsl_reg;
    logic signed [31:0] ab_reg, asl_reg;

    assign o_pending = force_q.size();

    function automatic longint fdiv(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sine_of(input logic [31:0] ang);
        logic [63:0] x, x2, p, y;
        x = {34'd0, ang[29:0]};
        if (ang[30]) x = 64'h4000_0000 - x;
        x2 = (x * x) >> 30;
        p = 64'd172272;
        p = 64'd5026995 - ((x2 * p) >> 30);
        p = 64'd85569306 - ((x2 * p) >> 30);
        p = 64'd693598669 - ((x2 * p) >> 30);
        p = 64'd1686629713 - ((x2 * p) >> 30);
        y = (x * p) >> 30;
        if (y > 64'h4000_0000) y = 64'h4000_0000;
        return ang[31] ? -longint'(y) : longint'(y);
    endfunction

    function automatic t_force bond_force(input logic signed [31:0] dx,
            input logic signed [31:0] dy, input logic signed [31:0] dz,
            input logic [30:0] t1, input logic [30:0] t2, input logic [31:0] ph);
        t_force      f;
        logic [63:0] rsq, r, rem, bit_v, ad, k2, q1, mag, dn;
        logic [31:0] theta;
        longint      rest, dr, a, fsv;
        rsq = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
        r = 0;
        rem = rsq;
        bit_v = 64'd1 << 62;
        while (bit_v > rem) bit_v >>= 2;
        while (bit_v != 0) begin
            if (rem >= r + bit_v) begin
                rem -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        rest = r0_reg;
        if (t1 >= first_reg && t1 <= last_reg && {1'b0, t2} == {1'b0, t1} + 32'd1) begin
            dn = t1 - first_reg;
            theta = 32'(fsl_reg * ((dn * dn) & 64'hFFFF_FFFF) + fb_reg * dn + ph);
            a = clamp32(longint'(asl_reg) * longint'(dn) + ab_reg);
            rest += fdiv(a * sine_of(theta), 30);
        end
        dr = longint'(r) - rest;
        fsv = 0;
        if (r != 0) begin
            ad = dr < 0 ? -dr : dr;
            k2 = 64'(k_reg) * 2;
            mag = 0;
            q1 = ad / r;
            if (k2 != 0) begin
                if (q1 > (64'd1 << 31) / k2) mag = 64'd1 << 31;
                else begin
                    mag = k2 * q1 + (k2 * (ad % r)) / r;
                    if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
                end
            end
            if (dr > 0) fsv = -longint'(mag);
            else fsv = mag > 64'd2147483647 ? 2147483647 : longint'(mag);
        end
        f.fx = clamp32(fdiv(fsv * dx, 16));
        f.fy = clamp32(fdiv(fsv * dy, 16));
        f.fz = clamp32(fdiv(fsv * dz, 16));
        f.fs = fsv;
        f.st = t1 >= t2;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_force got, want;
        if (!i_rst_n) begin
            k_reg <= 31'd65536; r0_reg <= 31'd65536;
            ab_reg <= '0; asl_reg <= '0; fb_reg <= '0; fsl_reg <= '0;
            first_reg <= '0; last_reg <= '0;
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_STIFFNESS:   k_reg <= i_cfg_data[30:0];
                    REG_REST_LENGTH: r0_reg <= i_cfg_data[30:0];
                    REG_AMP_BASE:    ab_reg <= i_cfg_data;
                    REG_AMP_SLOPE:   asl_reg <= i_cfg_data;
                    REG_FREQ_BASE:   fb_reg <= i_cfg_data;
                    REG_FREQ_SLOPE:  fsl_reg <= i_cfg_data;
                    REG_CHAIN_FIRST: first_reg <= i_cfg_data[30:0];
                    REG_CHAIN_LAST:  last_reg <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                force_q.push_back(bond_force(i_delta_x, i_delta_y, i_delta_z,
                    i_tag_first, i_tag_second, i_wave_phase));
            if (i_out_valid && i_out_ready) begin
                got = {i_force_x, i_force_y, i_force_z, i_force_scale, i_status};
                if (force_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected force transfer %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = force_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("force mismatch exp %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
                                want.fx, want.fy, want.fz, want.fs, want.st,
                                got.fx, got.fy, got.fz, got.fs, got.st);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bonds and register writes into the wave bond force block under
// several idle and stall mixes and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
    import swbf_pkg::*;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, i_in_valid = 0, i_out_ready = 0;
    logic [3:0] i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0, i_wave_phase = 0;
    logic signed [31:0] i_delta_x = 0, i_delta_y = 0, i_delta_z = 0;
    logic [30:0] i_tag_first = 0, i_tag_second = 0;
    logic o_cfg_ready, o_in_ready, o_out_valid, o_status;
    logic signed [31:0] o_force_x, o_force_y, o_force_z, o_force_scale;
    int errors, pending, send_idle, recv_stall, k;
    logic [30:0] chain_lo;

    always #5 i_clk = ~i_clk;

    swimmer_wave_bond_force dut (.*);

    tb_bond_checker chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_delta_x, .i_delta_y,
        .i_delta_z, .i_tag_first, .i_tag_second, .i_wave_phase,
        .i_out_valid(o_out_valid), .i_out_ready, .i_force_x(o_force_x),
        .i_force_y(o_force_y), .i_force_z(o_force_z), .i_force_scale(o_force_scale),
        .i_status(o_status), .o_errors(errors), .o_pending(pending));

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall);

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // entered and left at a falling edge
    task automatic send_bond(input logic [31:0] dx, dy, dz, input logic [30:0] t1, t2,
            input logic [31:0] ph);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_delta_x <= dx; i_delta_y <= dy; i_delta_z <= dz;
        i_tag_first <= t1; i_tag_second <= t2; i_wave_phase <= ph;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic random_bond();
        logic [30:0] t1;
        t1 = $urandom_range(3) == 0 ? 31'($urandom) : chain_lo + 31'($urandom_range(40));
        case ($urandom_range(3))
            0: send_bond(rand_word(), rand_word(), rand_word(), t1, 31'($urandom), $urandom);
            default: send_bond(rand_word(), rand_word(), rand_word(), t1,
                                 t1 + ($urandom_range(9) == 0 ? 0 : 1), $urandom);
        endcase
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        send_idle = 0; recv_stall = 0; chain_lo = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        send_bond(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0);
        send_bond(0, 0, 0, 5, 6, 0);
        send_bond(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_bond(32'h0001_0000, 0, 0, 3, 2, 0);
        send_bond(32'hFFFF_FFFF, 1, 0, 31'h7FFF_FFFF, 0, 32'h4000_0000);
        drain();
        write_reg(REG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(REG_REST_LENGTH, 32'h0003_0000);
        write_reg(REG_AMP_BASE, 32'h0001_8000);
        write_reg(REG_AMP_SLOPE, 32'hFFFF_F000);
        write_reg(REG_FREQ_BASE, 32'h1000_0000);
        write_reg(REG_FREQ_SLOPE, 32'h0100_0000);
        write_reg(REG_CHAIN_FIRST, 32'd10);
        write_reg(REG_CHAIN_LAST, 32'd30);
        write_reg(t_reg_idx'(4'd12), 32'hDEAD_BEEF);
        chain_lo = 8;
        for (k = 0; k < 16; k++)
            send_bond($urandom_range(32'h0004_0000), rand_word(), 0, 10 + k, 11 + k,
                      k[1:0] << 30);
        send_bond(32'h0002_0000, 0, 0, 31, 32, 0);
        send_bond(32'h0002_0000, 0, 0, 9, 10, 0);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle = ph == 1 ? 86 : ph == 3 ? 15 : 0;
            recv_stall = ph == 2 ? 86 : ph == 3 ? 15 : 0;
            case (ph)
                0: begin
                    write_reg(REG_STIFFNESS, 32'd0);
                    write_reg(REG_AMP_BASE, 32'h7FFF_FFFF);
                    write_reg(REG_AMP_SLOPE, 32'h7FFF_FFFF);
                    write_reg(REG_REST_LENGTH, 32'h7FFF_FFFF);
                end
                1: begin
                    write_reg(REG_STIFFNESS, 32'h0000_4000);
                    write_reg(REG_REST_LENGTH, 32'd0);
                    write_reg(REG_AMP_BASE, 32'h8000_0000);
                    write_reg(REG_FREQ_SLOPE, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(REG_STIFFNESS, $urandom);
                    write_reg(REG_REST_LENGTH, $urandom_range(32'h0008_0000));
                    write_reg(REG_AMP_BASE, $urandom);
                    write_reg(REG_AMP_SLOPE, $urandom);
                    write_reg(REG_FREQ_BASE, 32'hFFFF_FFFF);
                end
                default: begin
                    write_reg(REG_CHAIN_FIRST, 32'h7FFF_FFE0);
                    write_reg(REG_CHAIN_LAST, 32'h7FFF_FFFF);
                    chain_lo = 31'h7FFF_FFD8;
                end
            endcase
            for (k = 0; k < 410; k++) random_bond();
            drain();
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: swimmer_wave_bond_force.f
design/swbf_pkg.sv
design/swbf_isqrt.sv
design/swbf_div.sv
design/swimmer_wave_bond_force.sv
bench/tb_bond_checker.sv
bench/tb.sv
